FILE: src/button_debounce_command_decoder_macros.svh
// Assertion macros for the button debounce and command decoder.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef BUTTON_DEBOUNCE_COMMAND_DECODER_MACROS_SVH
`define BUTTON_DEBOUNCE_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bdcd_pkg.sv
// Shared types and constants for the button debounce and command decoder.
// No dependencies.
`default_nettype none

package bdcd_pkg;

    localparam int NUM_BUTTONS = 7;
    localparam int CFG_W       = 16;
    localparam int NOW_W       = 32;

    localparam logic CFG_SETTLE_MS     = 1'b0;
    localparam logic CFG_LONG_PRESS_MS = 1'b1;

    localparam logic [CFG_W-1:0] SETTLE_MS_RESET     = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_MS_RESET = 16'd1200;

    localparam int KEY_PAUSE     = 0;
    localparam int KEY_AGG_DOWN  = 1;
    localparam int KEY_AGG_UP    = 2;
    localparam int KEY_N_DOWN    = 3;
    localparam int KEY_N_UP      = 4;
    localparam int KEY_ZOOM_DOWN = 5;
    localparam int KEY_ZOOM_UP   = 6;

    localparam int CAL_PRESET_NEXT = 0;
    localparam int CAL_PRESET_PREV = 1;
    localparam int CAL_TARGET_UP   = 2;
    localparam int CAL_TARGET_DOWN = 3;
    localparam int CAL_UNDO        = 4;
    localparam int CAL_CAPTURE     = 5;
    localparam int CAL_FINISH      = 6;

    localparam int WAVE_Y_OUT  = 0;
    localparam int WAVE_Y_IN   = 1;
    localparam int WAVE_FS_OUT = 2;
    localparam int WAVE_FS_IN  = 3;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] raw_pressed;
        logic [NOW_W-1:0]       now_ms;
        logic                   calibrating;
    } t_in;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] press_edges;
        logic [6:0]             cal_actions;
        logic [5:0]             fft_actions;
        logic [3:0]             wave_actions;
        logic                   mode_toggled;
        logic                   display_mode_now;
    } t_out;

endpackage

`default_nettype wire

FILE: src/bdcd_debounce.sv
// One debounce lane: accepted level and time of the last accepted change.
// Depends on bdcd_pkg.
`default_nettype none

module bdcd_debounce #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_level,
    input  wire logic [TIME_BITS-1:0]       i_now,
    input  wire logic [bdcd_pkg::CFG_W-1:0] i_settle_ms,
    output logic                            o_edge
);

    logic                 r_level;
    logic [TIME_BITS-1:0] r_change_time;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_take;

    always_comb begin
        w_elapsed = i_now - r_change_time;
        w_take    = (i_level != r_level) && (w_elapsed >= TIME_BITS'(i_settle_ms));
        o_edge    = w_take && i_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= 1'b1;
            r_change_time <= '0;
        end else if (i_adv && w_take) begin
            r_level       <= i_level;
            r_change_time <= i_now;
        end
    end

endmodule

`default_nettype wire

FILE: src/bdcd_decode.sv
// Command decoder: pause press tracking, display mode and action mapping.
// Depends on bdcd_pkg.
`default_nettype none

module bdcd_decode #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_adv,
    input  wire logic [bdcd_pkg::NUM_BUTTONS-1:0] i_edges,
    input  wire logic                             i_raw_pause,
    input  wire logic                             i_cal,
    input  wire logic [TIME_BITS-1:0]             i_now,
    input  wire logic [bdcd_pkg::CFG_W-1:0]       i_long_press_ms,
    output bdcd_pkg::t_out                        o_result
);

    logic [TIME_BITS-1:0] r_down_time;
    logic                 r_armed;
    logic                 r_fired;
    logic                 r_mode;

    logic                 w_pause_edge;
    logic                 w_armed;
    logic                 w_fired;
    logic [TIME_BITS-1:0] w_down_time;
    logic [TIME_BITS-1:0] w_hold_time;
    logic                 w_finish;
    logic                 w_capture;
    logic                 w_toggle;
    logic                 w_mode;

    always_comb begin
        w_pause_edge = i_edges[bdcd_pkg::KEY_PAUSE];
        w_armed      = w_pause_edge || r_armed;
        w_fired      = !w_pause_edge && r_fired;
        w_down_time  = w_pause_edge ? i_now : r_down_time;
        w_hold_time  = i_now - w_down_time;
        w_finish     = i_raw_pause && w_armed && !w_fired &&
                       (w_hold_time >= TIME_BITS'(i_long_press_ms));
        w_capture    = !i_raw_pause && w_armed && !w_fired;
        w_toggle     = !i_cal && w_pause_edge;
        w_mode       = r_mode ^ w_toggle;

        o_result                  = '0;
        o_result.press_edges      = i_edges;
        o_result.mode_toggled     = w_toggle;
        o_result.display_mode_now = w_mode;
        if (i_cal) begin
            o_result.cal_actions[bdcd_pkg::CAL_PRESET_NEXT] = i_edges[bdcd_pkg::KEY_ZOOM_UP];
            o_result.cal_actions[bdcd_pkg::CAL_PRESET_PREV] = i_edges[bdcd_pkg::KEY_ZOOM_DOWN];
            o_result.cal_actions[bdcd_pkg::CAL_TARGET_UP]   = i_edges[bdcd_pkg::KEY_AGG_UP];
            o_result.cal_actions[bdcd_pkg::CAL_TARGET_DOWN] = i_edges[bdcd_pkg::KEY_AGG_DOWN];
            o_result.cal_actions[bdcd_pkg::CAL_UNDO]        = i_edges[bdcd_pkg::KEY_N_DOWN];
            o_result.cal_actions[bdcd_pkg::CAL_CAPTURE]     = w_capture;
            o_result.cal_actions[bdcd_pkg::CAL_FINISH]      = w_finish;
        end else if (!w_mode) begin
            o_result.fft_actions = i_edges[bdcd_pkg::NUM_BUTTONS-1:1];
        end else begin
            o_result.wave_actions[bdcd_pkg::WAVE_Y_OUT]  = i_edges[bdcd_pkg::KEY_AGG_DOWN];
            o_result.wave_actions[bdcd_pkg::WAVE_Y_IN]   = i_edges[bdcd_pkg::KEY_AGG_UP];
            o_result.wave_actions[bdcd_pkg::WAVE_FS_OUT] = i_edges[bdcd_pkg::KEY_ZOOM_DOWN];
            o_result.wave_actions[bdcd_pkg::WAVE_FS_IN]  = i_edges[bdcd_pkg::KEY_ZOOM_UP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_time <= '0;
            r_armed     <= 1'b0;
            r_fired     <= 1'b0;
            r_mode      <= 1'b0;
        end else if (i_adv) begin
            if (i_cal) begin
                r_down_time <= w_down_time;
                r_armed     <= i_raw_pause && w_armed;
                r_fired     <= w_fired || w_finish;
            end
            r_mode <= w_mode;
        end
    end

endmodule

`default_nettype wire

FILE: src/button_debounce_command_decoder.sv
// Top level of the button debounce and command decoder: request and result
// registers, configuration registers, seven debounce lanes and the decoder.
// Depends on bdcd_pkg, bdcd_debounce, bdcd_decode and the macros header.
//
//   channel   direction   handshake                     payload
//   request   in          i_in_valid / o_in_stall       i_in  (bdcd_pkg::t_in)
//   result    out         o_out_valid / i_out_stall     o_out (bdcd_pkg::t_out)
//   config    in          i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One request per cycle unless o_in_stall is high; the request and result registers lie between input and result.
// The request register feeds one pass of debounce and decode logic into the result register.
// Reset sets all button levels to pressed, times to zero and spectrum mode.
// A stalled result holds the result register; the request register then fills and stalls.
`default_nettype none

`include "button_debounce_command_decoder_macros.svh"

module button_debounce_command_decoder #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire bdcd_pkg::t_in              i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output bdcd_pkg::t_out                  o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [bdcd_pkg::CFG_W-1:0] i_cfg_data
);

    bdcd_pkg::t_in                    r_in;
    logic                             r_in_valid;
    bdcd_pkg::t_out                   r_out;
    logic                             r_out_valid;
    logic [bdcd_pkg::CFG_W-1:0]       r_settle_ms;
    logic [bdcd_pkg::CFG_W-1:0]       r_long_press_ms;

    logic                             w_adv;
    logic [TIME_BITS-1:0]             w_now;
    logic [bdcd_pkg::NUM_BUTTONS-1:0] w_edges;
    bdcd_pkg::t_out                   w_result;

    logic                             w_cal_out;
    logic                             w_disp_out;
    logic                             w_toggle_out;
    logic                             w_pause_out;
    logic                             w_both_ends;

    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_now       = r_in.now_ms[TIME_BITS-1:0];
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ms     <= bdcd_pkg::SETTLE_MS_RESET;
            r_long_press_ms <= bdcd_pkg::LONG_PRESS_MS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bdcd_pkg::CFG_SETTLE_MS:     r_settle_ms     <= i_cfg_data;
                bdcd_pkg::CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    for (genvar g = 0; g < bdcd_pkg::NUM_BUTTONS; g++) begin : g_lane
        bdcd_debounce #(
            .TIME_BITS(TIME_BITS)
        ) u_debounce (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_level    (r_in.raw_pressed[g]),
            .i_now      (w_now),
            .i_settle_ms(r_settle_ms),
            .o_edge     (w_edges[g])
        );
    end

    bdcd_decode #(
        .TIME_BITS(TIME_BITS)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_edges        (w_edges),
        .i_raw_pause    (r_in.raw_pressed[bdcd_pkg::KEY_PAUSE]),
        .i_cal          (r_in.calibrating),
        .i_now          (w_now),
        .i_long_press_ms(r_long_press_ms),
        .o_result       (w_result)
    );

    assign w_cal_out    = o_out_valid && (o_out.cal_actions != '0);
    assign w_disp_out   = (o_out.fft_actions != '0) || (o_out.wave_actions != '0) ||
                          o_out.mode_toggled;
    assign w_toggle_out = o_out_valid && o_out.mode_toggled;
    assign w_pause_out  = o_out.press_edges[bdcd_pkg::KEY_PAUSE];
    assign w_both_ends  = o_out.cal_actions[bdcd_pkg::CAL_CAPTURE] &&
                          o_out.cal_actions[bdcd_pkg::CAL_FINISH];

    `BDCD_ASSERT_NEXT(a_adv_fills_out, w_adv, o_out_valid, "Accepted request left no result.")
    `BDCD_ASSERT_NOW(a_cal_excl, w_cal_out, !w_disp_out, "Calibration and display actions together.")
    `BDCD_ASSERT_NOW(a_toggle_edge, w_toggle_out, w_pause_out, "Toggle without a pause edge.")
    `BDCD_ASSERT_NOW(a_short_long, o_out_valid, !w_both_ends, "Capture and finish together.")

endmodule

`default_nettype wire
